>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gbba_pkg.sv
// ----------------------------------------------------------------------------
// gbba_pkg
// types, codes and constants of the grouped bitmap block allocator
// ----------------------------------------------------------------------------
package gbba_pkg;

    localparam int DEF_MAX_GROUPS = 16;
    localparam int DEF_GROUP_BITS = 8192;
    localparam int GCNT_W         = 14;
    localparam int TOTAL_W        = 18;
    localparam int REG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 18;

    localparam logic [GCNT_W-1:0]  GCNT_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [REG_IDX_W-1:0] REG_GROUP_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_DATA    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOTAL_BLOCKS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_PROTECT = 3'd4;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_READ_ONLY = 2'd2,
        ST_NO_SPACE  = 2'd3
    } status_t;

    typedef struct packed {
        op_t          op;
        logic [3:0]   start_group;
        logic [17:0]  block_number;
    } alloc_req_t;

    typedef struct packed {
        status_t      status;
        logic [17:0]  allocated_block;
        logic [17:0]  free_total;
    } alloc_rsp_t;

    typedef struct packed {
        logic [4:0]   group_count;
        logic [13:0]  group_size;
        logic         first_data_block;
        logic [17:0]  volume_blocks;
        logic         write_protect;
    } cfg_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_SWEEP,
        CMD_BASE,
        CMD_INIT_LOAD,
        CMD_MOD,
        CMD_WORD_RD,
        CMD_CHK,
        CMD_ALLOC_WR,
        CMD_NEXT_GRP,
        CMD_DIV_START,
        CMD_DIV,
        CMD_FREE_RD,
        CMD_FREE_WR,
        CMD_RES_RO,
        CMD_RES_INV,
        CMD_RES_NOSPACE
    } dp_cmd_t;

    typedef struct packed {
        op_t   op;
        logic  write_protect;
        logic  total_zero;
        logic  blk_low;
        logic  sweep_last;
        logic  init_last;
        logic  mod_done;
        logic  grp_empty;
        logic  word_in_range;
        logic  word_full;
        logic  word_found;
        logic  grp_last;
        logic  div_done;
        logic  div_bad;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_INIT_CLR,
        S_INIT_BASE,
        S_INIT_LOAD,
        S_MOD,
        S_GRP,
        S_RD,
        S_CHK,
        S_WR,
        S_NEXT,
        S_DIV,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } ctrl_state_t;

endpackage

>>> hw/rtl/group_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// group_bitmap_block_allocator
// block allocator over per-group free bitmaps with group and total counters
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   start, busy, request               taken when start & !busy
//  result    done, result                       one-cycle strobe, no back-pressure
//  config    cfg_write, cfg_index, cfg_data     written when cfg_write is high
//
//  after reset a clearing pass zeroes every word of the bitmap ram, busy high
//  free finds the group by repeated subtraction, then reads the bitmap word and
//  writes it back with the bit cleared; allocate reduces the preferred group by
//  repeated subtraction, then tries each group in turn through the one ram port
//  init re-runs the clearing pass then loads the counter of every group
//  one request at a time; the result strobe cannot be stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module group_bitmap_block_allocator #(
    parameter int MAX_GROUPS = gbba_pkg::DEF_MAX_GROUPS,
    parameter int GROUP_BITS = gbba_pkg::DEF_GROUP_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  gbba_pkg::alloc_req_t                request,
    output logic                                done,
    output gbba_pkg::alloc_rsp_t                result,
    input  logic                                cfg_write,
    input  logic [gbba_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [gbba_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gbba_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration registers, writes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_GROUP_COUNT:   cfg_next.group_count      = cfg_data[4:0];
                REG_GROUP_SIZE:    cfg_next.group_size       = cfg_data[13:0];
                REG_FIRST_DATA:    cfg_next.first_data_block = cfg_data[0];
                REG_TOTAL_BLOCKS:  cfg_next.volume_blocks    = cfg_data[17:0];
                REG_WRITE_PROTECT: cfg_next.write_protect    = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{group_count: 5'd1, group_size: 14'd8192, first_data_block: 1'b1,
                         volume_blocks: 18'd8193, write_protect: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer
    gbba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // bitmap, counters and search logic
    gbba_dp #(
        .MAX_GROUPS (MAX_GROUPS),
        .GROUP_BITS (GROUP_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    // a word taken always makes the block busy next cycle
    `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
    // the result strobe only comes out of a running operation
    `ASSERT_SAME(a_done_busy, done, busy, "result strobe while idle")
    // after the result the block is free again
    `ASSERT_NEXT(a_done_idle, done, !busy && !done, "block stays busy after result")
    // only a granted allocation carries a block number
    `ASSERT_SAME(a_block_zero, done && (result.status != ST_OK), result.allocated_block == 18'd0,
        "block number on a failed word")

endmodule

>>> hw/rtl/gbba_ram.sv
// ----------------------------------------------------------------------------
// gbba_ram
// single port ram, registered read
// ----------------------------------------------------------------------------
module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/gbba_ctrl.sv
// ----------------------------------------------------------------------------
// gbba_ctrl
// sequencer for clear, init, allocate and free
// ----------------------------------------------------------------------------
module gbba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  gbba_pkg::dp_stat_t stat,
    output gbba_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done
);
    import gbba_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:     if (stat.sweep_last) state_next = S_IDLE;
            S_IDLE:      if (start) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_INIT:  state_next = S_INIT_CLR;
                    OP_ALLOC:
                    begin
                        if (stat.write_protect || stat.total_zero) state_next = S_DONE;
                        else                                        state_next = S_MOD;
                    end
                    OP_FREE:
                    begin
                        if (stat.write_protect || stat.blk_low) state_next = S_DONE;
                        else                                     state_next = S_DIV;
                    end
                    default:  state_next = S_DONE;
                endcase
            end
            S_INIT_CLR:  if (stat.sweep_last) state_next = S_INIT_BASE;
            S_INIT_BASE: state_next = S_INIT_LOAD;
            S_INIT_LOAD: state_next = stat.init_last ? S_DONE : S_INIT_BASE;
            S_MOD:       if (stat.mod_done) state_next = S_GRP;
            S_GRP:       state_next = stat.grp_empty ? S_NEXT : S_RD;
            S_RD:        state_next = stat.word_in_range ? S_CHK : S_NEXT;
            S_CHK:
            begin
                if (stat.word_full)       state_next = S_RD;
                else if (stat.word_found) state_next = S_WR;
                else                      state_next = S_NEXT;
            end
            S_WR:        state_next = S_DONE;
            S_NEXT:      state_next = stat.grp_last ? S_DONE : S_GRP;
            S_DIV:
            begin
                if (stat.div_done) state_next = stat.div_bad ? S_DONE : S_FREE_RD;
            end
            S_FREE_RD:   state_next = S_FREE_WR;
            S_FREE_WR:   state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = CMD_NONE;
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        case (state_reg)
            S_CLEAR:     cmd = CMD_SWEEP;
            S_IDLE:      if (start) cmd = CMD_LATCH;
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_ALLOC:
                    begin
                        if (stat.write_protect)   cmd = CMD_RES_RO;
                        else if (stat.total_zero) cmd = CMD_RES_NOSPACE;
                    end
                    OP_FREE:
                    begin
                        if (stat.write_protect) cmd = CMD_RES_RO;
                        else if (stat.blk_low)  cmd = CMD_RES_INV;
                        else                    cmd = CMD_DIV_START;
                    end
                    default: cmd = CMD_NONE;
                endcase
            end
            S_INIT_CLR:  cmd = CMD_SWEEP;
            S_INIT_BASE: cmd = CMD_BASE;
            S_INIT_LOAD: cmd = CMD_INIT_LOAD;
            S_MOD:       cmd = CMD_MOD;
            S_GRP:       cmd = CMD_BASE;
            S_RD:        cmd = CMD_WORD_RD;
            S_CHK:       cmd = CMD_CHK;
            S_WR:        cmd = CMD_ALLOC_WR;
            S_NEXT:      cmd = CMD_NEXT_GRP;
            S_DIV:       cmd = (stat.div_done && stat.div_bad) ? CMD_RES_INV : CMD_DIV;
            S_FREE_RD:   cmd = CMD_FREE_RD;
            S_FREE_WR:   cmd = CMD_FREE_WR;
            default:     cmd = CMD_NONE;
        endcase
    end

endmodule

>>> hw/rtl/gbba_dp.sv
// ----------------------------------------------------------------------------
// gbba_dp
// bitmap ram, group counters, search and release datapath
// ----------------------------------------------------------------------------
module gbba_dp #(
    parameter int MAX_GROUPS = gbba_pkg::DEF_MAX_GROUPS,
    parameter int GROUP_BITS = gbba_pkg::DEF_GROUP_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gbba_pkg::cfg_t       cfg,
    input  gbba_pkg::alloc_req_t request,
    input  gbba_pkg::dp_cmd_t    cmd,
    output gbba_pkg::dp_stat_t   stat,
    output gbba_pkg::alloc_rsp_t result
);
    import gbba_pkg::*;

    localparam int WPG   = GROUP_BITS / 32;
    localparam int WW    = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int WCW   = WW + 1;
    localparam int DEPTH = MAX_GROUPS * WPG;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);
    localparam int PW    = (GCW > 4) ? GCW : 4;
    localparam int BASEW = GW + 15;
    localparam int DW    = (BASEW > TOTAL_W) ? BASEW : TOTAL_W;
    localparam int IXW   = (WCW + 5 > GCNT_W) ? WCW + 5 : GCNT_W;

    alloc_req_t          req_reg,    req_next;
    status_t             status_reg, status_next;
    logic [17:0]         block_reg,  block_next;
    logic [TOTAL_W-1:0]  total_reg,  total_next;
    logic [GCNT_W-1:0]   cnt_reg [MAX_GROUPS];
    logic [GCNT_W-1:0]   cnt_next [MAX_GROUPS];
    logic [GW-1:0]       g_reg,      g_next;
    logic [GCW-1:0]      iter_reg,   iter_next;
    logic [PW-1:0]       r_reg,      r_next;
    logic [WCW-1:0]      w_reg,      w_next;
    logic [BASEW-1:0]    base_reg,   base_next;
    logic [17:0]         rem_reg,    rem_next;
    logic [AW-1:0]       sweep_reg,  sweep_next;
    logic [AW-1:0]       waddr_reg,  waddr_next;
    logic [31:0]         wword_reg,  wword_next;
    logic [IXW-1:0]      idx_reg,    idx_next;

    logic [GCW-1:0]      gc;
    logic [GCNT_W-1:0]   gs;
    logic [GCNT_W-1:0]   limit;
    logic [DW-1:0]       diff;
    logic                last_grp;
    logic [4:0]          zb;
    logic [IXW-1:0]      idx;
    logic                full;
    logic                in_range;
    logic                found;
    logic [AW-1:0]       alloc_addr;
    logic [AW-1:0]       free_addr;
    logic                div_cond;
    logic [GCNT_W-1:0]   init_n;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [31:0]         ram_wdata;
    logic [31:0]         rdata;

    gbba_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    // effective group count and size
    always_comb
    begin
        if (cfg.group_count == 5'd0)                gc = GCW'(1);
        else if (32'(cfg.group_count) > MAX_GROUPS) gc = GCW'(MAX_GROUPS);
        else                                         gc = GCW'(cfg.group_count);

        if (cfg.group_size < 14'd8)                  gs = 14'd8;
        else if (32'(cfg.group_size) > GROUP_BITS)   gs = GCNT_W'(GROUP_BITS);
        else                                         gs = cfg.group_size;
    end

    // real size of the current group, base_reg holds its first block
    assign last_grp = ((GCW + 1)'(g_reg) + (GCW + 1)'(1)) >= (GCW + 1)'(gc);
    assign diff     = DW'(cfg.volume_blocks) - DW'(base_reg);

    always_comb
    begin
        if (!last_grp)                                       limit = gs;
        else if (DW'(cfg.volume_blocks) <= DW'(base_reg))    limit = '0;
        else if (diff < DW'(gs))                             limit = GCNT_W'(diff);
        else                                                 limit = gs;
    end

    // lowest clear bit of the word just read
    always_comb
    begin
        zb = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!rdata[i]) zb = 5'(i);
        end
    end

    assign full       = &rdata;
    assign idx        = IXW'({w_reg[WW-1:0], zb});
    assign in_range   = IXW'({w_reg, 5'b0}) < IXW'(limit);
    assign found      = idx < IXW'(limit);
    assign alloc_addr = AW'(g_reg) * AW'(WPG) + AW'(w_reg);
    assign free_addr  = AW'(iter_reg) * AW'(WPG) + AW'(rem_reg >> 5);
    assign div_cond   = (rem_reg >= 18'(gs)) && (iter_reg < gc);
    assign init_n     = (GCW'(g_reg) < gc) ? limit : '0;

    always_comb
    begin
        stat.op            = req_reg.op;
        stat.write_protect = cfg.write_protect;
        stat.total_zero    = (total_reg == '0);
        stat.blk_low       = req_reg.block_number < 18'(cfg.first_data_block);
        stat.sweep_last    = (sweep_reg == AW'(DEPTH - 1));
        stat.init_last     = (g_reg == GW'(MAX_GROUPS - 1));
        stat.mod_done      = r_reg < PW'(gc);
        stat.grp_empty     = (cnt_reg[g_reg] == '0);
        stat.word_in_range = in_range;
        stat.word_full     = full;
        stat.word_found    = found;
        stat.grp_last      = (iter_reg == (gc - GCW'(1)));
        stat.div_done      = !div_cond;
        stat.div_bad       = (iter_reg >= gc);
    end

    always_comb
    begin
        req_next    = req_reg;
        status_next = status_reg;
        block_next  = block_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        g_next      = g_reg;
        iter_next   = iter_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        base_next   = base_reg;
        rem_next    = rem_reg;
        sweep_next  = sweep_reg;
        waddr_next  = waddr_reg;
        wword_next  = wword_reg;
        idx_next    = idx_reg;
        ram_we      = 1'b0;
        ram_addr    = waddr_reg;
        ram_wdata   = '0;
        case (cmd)
            CMD_LATCH:
            begin
                req_next    = request;
                status_next = ST_OK;
                block_next  = '0;
                g_next      = '0;
                r_next      = PW'(request.start_group);
            end
            CMD_SWEEP:
            begin
                ram_we     = 1'b1;
                ram_addr   = sweep_reg;
                sweep_next = stat.sweep_last ? '0 : sweep_reg + AW'(1);
            end
            CMD_BASE:
            begin
                base_next = BASEW'(cfg.first_data_block) + BASEW'(g_reg) * BASEW'(gs);
                w_next    = '0;
            end
            CMD_INIT_LOAD:
            begin
                cnt_next[g_reg] = init_n;
                total_next = ((g_reg == '0) ? '0 : total_reg) + TOTAL_W'(init_n);
                g_next     = stat.init_last ? '0 : g_reg + GW'(1);
            end
            CMD_MOD:
            begin
                if (r_reg >= PW'(gc))
                begin
                    r_next = r_reg - PW'(gc);
                end
                else
                begin
                    g_next    = GW'(r_reg);
                    iter_next = '0;
                end
            end
            CMD_WORD_RD:
            begin
                ram_addr   = alloc_addr;
                waddr_next = alloc_addr;
            end
            CMD_CHK:
            begin
                if (full)
                begin
                    w_next = w_reg + WCW'(1);
                end
                else
                begin
                    wword_next = rdata | (32'd1 << zb);
                    idx_next   = idx;
                end
            end
            CMD_ALLOC_WR:
            begin
                ram_we          = 1'b1;
                ram_wdata       = wword_reg;
                cnt_next[g_reg] = cnt_reg[g_reg] - GCNT_W'(1);
                total_next      = total_reg - TOTAL_W'(1);
                block_next      = 18'(base_reg + BASEW'(idx_reg));
                status_next     = ST_OK;
            end
            CMD_NEXT_GRP:
            begin
                iter_next = iter_reg + GCW'(1);
                g_next    = last_grp ? '0 : g_reg + GW'(1);
                if (stat.grp_last) status_next = ST_NO_SPACE;
            end
            CMD_DIV_START:
            begin
                rem_next  = req_reg.block_number - 18'(cfg.first_data_block);
                iter_next = '0;
            end
            CMD_DIV:
            begin
                if (div_cond)
                begin
                    rem_next  = rem_reg - 18'(gs);
                    iter_next = iter_reg + GCW'(1);
                end
            end
            CMD_FREE_RD:
            begin
                ram_addr   = free_addr;
                waddr_next = free_addr;
                g_next     = GW'(iter_reg);
            end
            CMD_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata & ~(32'd1 << rem_reg[4:0]);
                if (cnt_reg[g_reg] != GCNT_MAX) cnt_next[g_reg] = cnt_reg[g_reg] + GCNT_W'(1);
                if (total_reg != TOTAL_MAX)     total_next = total_reg + TOTAL_W'(1);
                status_next = ST_OK;
            end
            CMD_RES_RO:      status_next = ST_READ_ONLY;
            CMD_RES_INV:     status_next = ST_INVALID;
            CMD_RES_NOSPACE: status_next = ST_NO_SPACE;
            default:         status_next = status_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_OK;
            block_reg  <= '0;
            total_reg  <= '0;
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            g_reg      <= '0;
            iter_reg   <= '0;
            r_reg      <= '0;
            w_reg      <= '0;
            sweep_reg  <= '0;
        end
        else
        begin
            status_reg <= status_next;
            block_reg  <= block_next;
            total_reg  <= total_next;
            cnt_reg    <= cnt_next;
            g_reg      <= g_next;
            iter_reg   <= iter_next;
            r_reg      <= r_next;
            w_reg      <= w_next;
            sweep_reg  <= sweep_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        base_reg  <= base_next;
        rem_reg   <= rem_next;
        waddr_reg <= waddr_next;
        wword_reg <= wword_next;
        idx_reg   <= idx_next;
    end

    assign result = '{status: status_reg, allocated_block: block_reg, free_total: total_reg};

endmodule
